// File: src/mi3_pkg.sv
// Shared widths, cofactor index table, lane result type and saturation helper.
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int ElemW       = 32;
  localparam int NumElem     = 9;
  localparam int ProdW       = 2 * ElemW;
  localparam int CofW        = ProdW + 1;
  localparam int CmagW       = ProdW;
  localparam int PartW       = CofW;
  localparam int TermW       = 3 * ElemW + 1;
  localparam int DmagW       = 3 * ElemW;
  localparam int QW          = ElemW + 1;
  localparam int NumQBits    = QW;
  localparam int SatW        = CofW;
  localparam int FrontStages = 6;
  localparam int LaneStages  = NumQBits + 2;
  localparam int NumStages   = FrontStages + LaneStages + 1;
  localparam int NumDetTerms = 3;

  // cofactor k = m[p0]*m[p1] - m[q0]*m[q1], row-major inverse order
  localparam logic [3:0] CofIdx [NumElem][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // det = m8*C8 + m2*C6 + m5*C7
  localparam logic [3:0] DetCof  [NumDetTerms] = '{4'd8, 4'd6, 4'd7};
  localparam logic [3:0] DetElem [NumDetTerms] = '{4'd8, 4'd2, 4'd5};

  localparam logic [SatW-1:0] MaxPosMag = SatW'(64'h0000_0000_7FFF_FFFF);
  localparam logic [SatW-1:0] MaxNegMag = SatW'(64'h0000_0000_8000_0000);

  typedef struct packed {
    logic [ElemW-1:0] val;
    logic             ovf;
  } lane_res_t;

  function automatic lane_res_t sat32(input logic [SatW-1:0] mag, input logic neg);
    lane_res_t r;
    logic [ElemW-1:0] m;
    m = mag[ElemW-1:0];
    if (neg) begin
      r.ovf = mag > MaxNegMag;
      r.val = r.ovf ? MaxNegMag[ElemW-1:0] : (~m + ElemW'(1));
    end else begin
      r.ovf = mag > MaxPosMag;
      r.val = r.ovf ? MaxPosMag[ElemW-1:0] : m;
    end
    return r;
  endfunction

endpackage

// File: src/mi3_front.sv
// Front end: pair products, cofactors, determinant and its magnitude.
`timescale 1ns / 1ps
module mi3_front import mi3_pkg::*; (
  input  logic                    clk_i,
  input  logic [FrontStages-1:0]  en_i,
  input  logic signed [ElemW-1:0] m_i [NumElem],
  output logic [CmagW-1:0]        cmag_o [NumElem],
  output logic                    cneg_o [NumElem],
  output logic [DmagW-1:0]        dmag_o,
  output logic                    dneg_o,
  output logic                    dzero_o
);

  logic signed [ProdW-1:0] pa_q [NumElem];
  logic signed [ProdW-1:0] pb_q [NumElem];
  logic signed [ElemW-1:0] mk1_q [NumDetTerms];
  logic signed [ElemW-1:0] mk2_q [NumDetTerms];
  logic signed [CofW-1:0]  c_q [NumElem];
  logic signed [PartW-1:0] hi_q [NumDetTerms];
  logic signed [PartW-1:0] lo_q [NumDetTerms];
  logic signed [TermW-1:0] term_q [NumDetTerms];
  logic signed [TermW-1:0] d_q;
  logic [DmagW-1:0]        dmag_q;
  logic                    dneg_q;
  logic                    dzero_q;
  logic [CmagW-1:0]        cmag_q [4][NumElem];
  logic                    cneg_q [4][NumElem];
  logic [CmagW-1:0]        cabs [NumElem];
  logic signed [TermW-1:0] dabs;

  always_comb begin
    for (int k = 0; k < NumElem; k++) begin
      cabs[k] = c_q[k][CofW-1] ? CmagW'(-c_q[k]) : CmagW'(c_q[k]);
    end
    dabs = d_q[TermW-1] ? -d_q : d_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int k = 0; k < NumElem; k++) begin
        pa_q[k] <= ProdW'(m_i[CofIdx[k][0]]) * ProdW'(m_i[CofIdx[k][1]]);
        pb_q[k] <= ProdW'(m_i[CofIdx[k][2]]) * ProdW'(m_i[CofIdx[k][3]]);
      end
      for (int j = 0; j < NumDetTerms; j++) mk1_q[j] <= m_i[DetElem[j]];
    end
    if (en_i[1]) begin
      for (int k = 0; k < NumElem; k++) c_q[k] <= CofW'(pa_q[k]) - CofW'(pb_q[k]);
      mk2_q <= mk1_q;
    end
    if (en_i[2]) begin
      for (int j = 0; j < NumDetTerms; j++) begin
        hi_q[j] <= PartW'($signed(c_q[DetCof[j]][CofW-1:ElemW])) * PartW'(mk2_q[j]);
        lo_q[j] <= PartW'($signed({1'b0, c_q[DetCof[j]][ElemW-1:0]})) * PartW'(mk2_q[j]);
      end
      for (int k = 0; k < NumElem; k++) begin
        cmag_q[0][k] <= cabs[k];
        cneg_q[0][k] <= c_q[k][CofW-1];
      end
    end
    if (en_i[3]) begin
      for (int j = 0; j < NumDetTerms; j++) begin
        term_q[j] <= (TermW'(hi_q[j]) <<< ElemW) + TermW'(lo_q[j]);
      end
      cmag_q[1] <= cmag_q[0];
      cneg_q[1] <= cneg_q[0];
    end
    if (en_i[4]) begin
      d_q        <= term_q[0] + term_q[1] + term_q[2];
      cmag_q[2] <= cmag_q[1];
      cneg_q[2] <= cneg_q[1];
    end
    if (en_i[5]) begin
      dmag_q     <= dabs[DmagW-1:0];
      dneg_q     <= d_q[TermW-1];
      dzero_q    <= (d_q == '0);
      cmag_q[3] <= cmag_q[2];
      cneg_q[3] <= cneg_q[2];
    end
  end

  assign cmag_o  = cmag_q[3];
  assign cneg_o  = cneg_q[3];
  assign dmag_o  = dmag_q;
  assign dneg_o  = dneg_q;
  assign dzero_o = dzero_q;

endmodule

// File: src/mi3_lane.sv
// Divider lane: one inverse element, restoring division one quotient bit per stage.
`timescale 1ns / 1ps
module mi3_lane import mi3_pkg::*; (
  input  logic                  clk_i,
  input  logic [LaneStages-1:0] en_i,
  input  logic [CmagW-1:0]      cmag_i,
  input  logic                  cneg_i,
  input  logic [DmagW-1:0]      dmag_i,
  input  logic                  dneg_i,
  output lane_res_t             res_o
);

  logic [DmagW-1:0] r_q   [NumQBits+1];
  logic [QW-1:0]    q_q   [NumQBits+1];
  logic [DmagW-1:0] d_q   [NumQBits+1];
  logic             neg_q [NumQBits+1];
  logic             big_q [NumQBits+1];
  logic             b0_q;
  lane_res_t        res_q;
  lane_res_t        res_d;
  logic             up;
  logic [QW:0]      qr;

  // quotient of 2^33 or more saturates whatever the rounding
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r_q[0]   <= DmagW'(cmag_i >> 1);
      q_q[0]   <= '0;
      d_q[0]   <= dmag_i;
      neg_q[0] <= cneg_i ^ dneg_i;
      big_q[0] <= {{(DmagW-CmagW+1){1'b0}}, cmag_i} >= {dmag_i, 1'b0};
      b0_q     <= cmag_i[0];
    end
  end

  for (genvar j = 1; j <= NumQBits; j++) begin : g_bit
    logic [DmagW:0] r2;
    logic [DmagW:0] rn;
    logic           ge;
    always_comb begin
      r2 = {r_q[j-1], (j == 1) ? b0_q : 1'b0};
      ge = r2 >= {1'b0, d_q[j-1]};
      rn = ge ? (r2 - {1'b0, d_q[j-1]}) : r2;
    end
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        r_q[j]   <= rn[DmagW-1:0];
        q_q[j]   <= {q_q[j-1][QW-2:0], ge};
        d_q[j]   <= d_q[j-1];
        neg_q[j] <= neg_q[j-1];
        big_q[j] <= big_q[j-1];
      end
    end
  end

  always_comb begin
    up    = {r_q[NumQBits], 1'b0} >= {1'b0, d_q[NumQBits]};
    qr    = {1'b0, q_q[NumQBits]} + (QW+1)'(up);
    res_d = sat32(SatW'(qr), neg_q[NumQBits]);
    if (big_q[NumQBits]) begin
      res_d.ovf = 1'b1;
      res_d.val = neg_q[NumQBits] ? MaxNegMag[ElemW-1:0] : MaxPosMag[ElemW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[LaneStages-1]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// File: src/matrix_inverse_3x3_top.sv
// 3x3 matrix inverse top level: front end, nine divider lanes, merge and output register.
`timescale 1ns / 1ps
// Inverts one 3x3 Q16.16 matrix per request by the adjugate. Fully pipelined: a new
// request is taken every cycle unless a stalled output has backed up to the first
// stage. Each result passes 6 front-end stages of products and sums, 35 stages of
// the nine bit-per-stage divider lanes and one merge/output register. Each stage has
// a valid bit, so empty stages keep filling while the output waits. A zero determinant
// gives zero inverse and determinant with singular set; else saturation sets overflow.
module matrix_inverse_3x3_top import mi3_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [ElemW-1:0] a_r0c0_i,
  input  logic signed [ElemW-1:0] a_r0c1_i,
  input  logic signed [ElemW-1:0] a_r0c2_i,
  input  logic signed [ElemW-1:0] a_r1c0_i,
  input  logic signed [ElemW-1:0] a_r1c1_i,
  input  logic signed [ElemW-1:0] a_r1c2_i,
  input  logic signed [ElemW-1:0] a_r2c0_i,
  input  logic signed [ElemW-1:0] a_r2c1_i,
  input  logic signed [ElemW-1:0] a_r2c2_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [ElemW-1:0] inv_r0c0_o,
  output logic signed [ElemW-1:0] inv_r0c1_o,
  output logic signed [ElemW-1:0] inv_r0c2_o,
  output logic signed [ElemW-1:0] inv_r1c0_o,
  output logic signed [ElemW-1:0] inv_r1c1_o,
  output logic signed [ElemW-1:0] inv_r1c2_o,
  output logic signed [ElemW-1:0] inv_r2c0_o,
  output logic signed [ElemW-1:0] inv_r2c1_o,
  output logic signed [ElemW-1:0] inv_r2c2_o,
  output logic signed [ElemW-1:0] determinant_o,
  output logic                    singular_o,
  output logic                    overflow_o
);

  localparam logic [DmagW:0] RoundHalf = (DmagW+1)'(64'h0000_0000_8000_0000);

  logic [NumStages-1:0] v_q, v_d, en;
  logic signed [ElemW-1:0] m [NumElem];
  logic [CmagW-1:0] cmag [NumElem];
  logic             cneg [NumElem];
  logic [DmagW-1:0] dmag;
  logic             dneg, dzero;
  lane_res_t        lane_res [NumElem];
  lane_res_t        det_q [LaneStages];
  logic             dz_q [LaneStages];
  logic [DmagW:0]   dsum;
  logic             lane_ovf;
  logic [ElemW-1:0] inv_q [NumElem];
  logic [ElemW-1:0] det_out_q;
  logic             sing_q, ovf_q;

  // stall chain: a stage loads when it is empty or its successor loads
  assign en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
  for (genvar s = 0; s < NumStages - 1; s++) begin : g_en
    assign en[s] = !v_q[s] || en[s+1];
  end

  always_comb begin
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int s = 1; s < NumStages; s++) v_d[s] = en[s] ? v_q[s-1] : v_q[s];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o = en[0];

  assign m[0] = a_r0c0_i;
  assign m[1] = a_r0c1_i;
  assign m[2] = a_r0c2_i;
  assign m[3] = a_r1c0_i;
  assign m[4] = a_r1c1_i;
  assign m[5] = a_r1c2_i;
  assign m[6] = a_r2c0_i;
  assign m[7] = a_r2c1_i;
  assign m[8] = a_r2c2_i;

  mi3_front u_front (
    .clk_i  (clk_i),
    .en_i   (en[FrontStages-1:0]),
    .m_i    (m),
    .cmag_o (cmag),
    .cneg_o (cneg),
    .dmag_o (dmag),
    .dneg_o (dneg),
    .dzero_o(dzero)
  );

  for (genvar k = 0; k < NumElem; k++) begin : g_lane
    mi3_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en[FrontStages +: LaneStages]),
      .cmag_i(cmag[k]),
      .cneg_i(cneg[k]),
      .dmag_i(dmag),
      .dneg_i(dneg),
      .res_o (lane_res[k])
    );
  end

  // determinant rounding runs beside the lanes
  assign dsum = {1'b0, dmag} + RoundHalf;

  always_ff @(posedge clk_i) begin
    if (en[FrontStages]) begin
      det_q[0] <= sat32(dsum[DmagW:ElemW], dneg);
      dz_q[0]  <= dzero;
    end
    for (int s = 1; s < LaneStages; s++) begin
      if (en[FrontStages+s]) begin
        det_q[s] <= det_q[s-1];
        dz_q[s]  <= dz_q[s-1];
      end
    end
  end

  always_comb begin
    lane_ovf = det_q[LaneStages-1].ovf;
    for (int k = 0; k < NumElem; k++) lane_ovf = lane_ovf | lane_res[k].ovf;
  end

  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      for (int k = 0; k < NumElem; k++) begin
        inv_q[k] <= dz_q[LaneStages-1] ? '0 : lane_res[k].val;
      end
      det_out_q <= dz_q[LaneStages-1] ? '0 : det_q[LaneStages-1].val;
      sing_q    <= dz_q[LaneStages-1];
      ovf_q     <= !dz_q[LaneStages-1] && lane_ovf;
    end
  end

  assign out_valid_o   = v_q[NumStages-1];
  assign inv_r0c0_o    = inv_q[0];
  assign inv_r0c1_o    = inv_q[1];
  assign inv_r0c2_o    = inv_q[2];
  assign inv_r1c0_o    = inv_q[3];
  assign inv_r1c1_o    = inv_q[4];
  assign inv_r1c2_o    = inv_q[5];
  assign inv_r2c0_o    = inv_q[6];
  assign inv_r2c1_o    = inv_q[7];
  assign inv_r2c2_o    = inv_q[8];
  assign determinant_o = det_out_q;
  assign singular_o    = sing_q;
  assign overflow_o    = ovf_q;

  a_singular_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> !overflow_o && determinant_o == '0 && inv_r1c1_o == '0)
    else $error("singular result carries nonzero data");

  a_empty_out_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[NumStages-1] |-> in_ready_o)
    else $error("input stalled with empty output stage");

  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted request lost at first stage");

endmodule
